[sv/assert_macros.svh]
// assertion helpers, sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RWB_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`define RWB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/rwbbc_pkg.sv]
package rwbbc_pkg;

    localparam int NODE_BITS         = 10;
    localparam int NODES             = 1 << NODE_BITS;
    localparam int DEG_WIDTH         = 12;
    localparam int PROB_WIDTH        = 32;
    localparam int STEP_WIDTH        = 7;
    localparam int BITC_WIDTH        = 4;
    localparam int CFG_IDX_WIDTH     = 1;
    localparam int CFG_DATA_WIDTH    = 7;
    localparam int DEFAULT_MAX_EDGES = 2048;

    typedef logic [NODE_BITS-1:0]  node_t;
    typedef logic [PROB_WIDTH-1:0] prob_t;
    typedef logic [DEG_WIDTH-1:0]  deg_t;
    typedef logic [STEP_WIDTH-1:0] step_t;
    typedef logic [BITC_WIDTH-1:0] bitc_t;

    localparam node_t NODE_MASK    = '1;
    localparam deg_t  DEG_MAX      = '1;
    localparam prob_t PROB_ONE     = prob_t'(1) << (PROB_WIDTH - 2);
    localparam prob_t PROB_QUARTER = prob_t'(1) << (PROB_WIDTH - 4);
    localparam prob_t PROB_LO      = PROB_QUARTER + prob_t'(1);
    localparam prob_t PROB_HI      = prob_t'(3) * PROB_QUARTER - prob_t'(1);

    localparam logic [CFG_IDX_WIDTH-1:0] REG_STEP_COUNT = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BIT_COUNT  = 1'd1;

    localparam step_t STEP_COUNT_RESET = 7'd1;
    localparam bitc_t BIT_COUNT_RESET  = 4'd1;

    typedef struct packed {
        logic  edge_valid;
        node_t node_a;
        node_t node_b;
        logic  last_edge;
    } in_item_t;

    typedef struct packed {
        logic  balanced;
        step_t failed_step;
    } out_item_t;

    typedef struct packed {
        logic in_rdy;
        logic clr_cnt;
        logic node_rst;
        logic node_inc;
        logic edge_rst;
        logic edge_inc;
        logic step_rst;
        logic step_inc;
        logic side;
        logic deg_clr_wr;
        logic edge_rd;
        logic deg_rd;
        logic deg_inc_wr;
        logic cur_init_wr;
        logic cur_rd_node;
        logic sum_clr;
        logic sum_acc;
        logic nxt_clr_wr;
        logic src_rd;
        logic div_start;
        logic nxt_rd_dst;
        logic nxt_add_wr;
        logic nxt_rd_node;
        logic cur_copy_wr;
        logic out_load;
        logic out_bal;
    } dp_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic node_last;
        logic edge_none;
        logic edge_last;
        logic step_end;
        logic bits_ok;
        logic div_done;
        logic deg_zero;
        logic out_free;
    } dp_sts_t;

    function automatic prob_t sat_add(input prob_t a, input prob_t b);
        logic [PROB_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PROB_WIDTH] ? '1 : s[PROB_WIDTH-1:0];
    endfunction

endpackage

[sv/rwbbc_if.sv]
interface rwbbc_in_if;
    import rwbbc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rwbbc_out_if;
    import rwbbc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/rwbbc_ram.sv]
module rwbbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/rwbbc_div.sv]
module rwbbc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rwbbc_pkg::prob_t dividend,
    input  rwbbc_pkg::deg_t  divisor,
    output rwbbc_pkg::prob_t quotient,
    output logic             done
);
    import rwbbc_pkg::*;

    localparam int CW = $clog2(PROB_WIDTH);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    prob_t         quo_reg, quo_next;
    deg_t          rem_reg, rem_next;
    deg_t          dsr_reg, dsr_next;
    logic [DEG_WIDTH:0] shifted;
    logic               take;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[PROB_WIDTH-1]};
        take      = shifted >= {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? deg_t'(shifted - {1'b0, dsr_reg}) : shifted[DEG_WIDTH-1:0];
            quo_next = {quo_reg[PROB_WIDTH-2:0], take};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(PROB_WIDTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = !busy_reg;

endmodule

[sv/rwbbc_dp.sv]
module rwbbc_dp #(
    parameter int MAX_EDGES = rwbbc_pkg::DEFAULT_MAX_EDGES
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    rwbbc_in_if.sink                                   in_ch,
    rwbbc_out_if.source                                out_ch,
    input  logic                                       cfg_we,
    input  logic [rwbbc_pkg::CFG_IDX_WIDTH-1:0]        cfg_idx,
    input  logic [rwbbc_pkg::CFG_DATA_WIDTH-1:0]       cfg_wdata,
    input  rwbbc_pkg::dp_cmd_t                         cmd,
    output rwbbc_pkg::dp_sts_t                         sts
);
    import rwbbc_pkg::*;

    localparam int EA_W  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);

    step_t            step_count_reg;
    bitc_t            bit_count_reg;
    logic [CNT_W-1:0] cnt_reg;
    node_t            node_reg;
    logic [EA_W-1:0]  edge_reg;
    step_t            step_reg;
    prob_t            sum_reg [NODE_BITS];
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    bitc_t  nb;
    node_t  mask;
    logic   in_fire;
    logic   e_we;
    node_t  ea_q, eb_q, src, dst;
    deg_t   deg_q;
    prob_t  cur_q, nxt_q, quo;
    logic   div_done;
    logic   bits_ok;

    always_comb
    begin
        if (bit_count_reg == '0)
        begin
            nb = bitc_t'(1);
        end
        else if (bit_count_reg > bitc_t'(NODE_BITS))
        begin
            nb = bitc_t'(NODE_BITS);
        end
        else
        begin
            nb = bit_count_reg;
        end
    end

    assign mask    = NODE_MASK >> (bitc_t'(NODE_BITS) - nb);
    assign in_fire = in_ch.valid && cmd.in_rdy;
    assign e_we    = in_fire && in_ch.data.edge_valid && (cnt_reg < CNT_W'(MAX_EDGES));
    assign src     = (cmd.side ? eb_q : ea_q) & mask;
    assign dst     = (cmd.side ? ea_q : eb_q) & mask;

    rwbbc_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_EDGES)) u_edge_a (
        .clk   (clk),
        .we    (e_we),
        .waddr (cnt_reg[EA_W-1:0]),
        .wdata (in_ch.data.node_a),
        .re    (cmd.edge_rd),
        .raddr (edge_reg),
        .rdata (ea_q)
    );

    rwbbc_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_EDGES)) u_edge_b (
        .clk   (clk),
        .we    (e_we),
        .waddr (cnt_reg[EA_W-1:0]),
        .wdata (in_ch.data.node_b),
        .re    (cmd.edge_rd),
        .raddr (edge_reg),
        .rdata (eb_q)
    );

    rwbbc_ram #(.WIDTH(DEG_WIDTH), .DEPTH(NODES)) u_deg (
        .clk   (clk),
        .we    (cmd.deg_clr_wr || cmd.deg_inc_wr),
        .waddr (cmd.deg_clr_wr ? node_reg : src),
        .wdata (cmd.deg_clr_wr ? '0 : ((deg_q == DEG_MAX) ? deg_q : deg_q + deg_t'(1))),
        .re    (cmd.deg_rd || cmd.src_rd),
        .raddr (src),
        .rdata (deg_q)
    );

    rwbbc_ram #(.WIDTH(PROB_WIDTH), .DEPTH(NODES)) u_cur (
        .clk   (clk),
        .we    (cmd.cur_init_wr || cmd.cur_copy_wr),
        .waddr (node_reg),
        .wdata (cmd.cur_init_wr ? (PROB_ONE >> nb) : nxt_q),
        .re    (cmd.cur_rd_node || cmd.src_rd),
        .raddr (cmd.cur_rd_node ? node_reg : src),
        .rdata (cur_q)
    );

    rwbbc_ram #(.WIDTH(PROB_WIDTH), .DEPTH(NODES)) u_nxt (
        .clk   (clk),
        .we    (cmd.nxt_clr_wr || cmd.nxt_add_wr),
        .waddr (cmd.nxt_clr_wr ? node_reg : dst),
        .wdata (cmd.nxt_clr_wr ? '0 : sat_add(nxt_q, quo)),
        .re    (cmd.nxt_rd_dst || cmd.nxt_rd_node),
        .raddr (cmd.nxt_rd_node ? node_reg : dst),
        .rdata (nxt_q)
    );

    rwbbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cur_q),
        .divisor  (deg_q),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb
    begin
        bits_ok = 1'b1;
        for (int b = 0; b < NODE_BITS; b++)
        begin
            if ((bitc_t'(b) < nb) && !((sum_reg[b] > PROB_LO) && (sum_reg[b] < PROB_HI)))
            begin
                bits_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= STEP_COUNT_RESET;
            bit_count_reg  <= BIT_COUNT_RESET;
            cnt_reg        <= '0;
            node_reg       <= '0;
            edge_reg       <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_idx == REG_STEP_COUNT))
            begin
                step_count_reg <= cfg_wdata[STEP_WIDTH-1:0];
            end
            if (cfg_we && (cfg_idx == REG_BIT_COUNT))
            begin
                bit_count_reg <= cfg_wdata[BITC_WIDTH-1:0];
            end
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (e_we)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.node_rst)
            begin
                node_reg <= '0;
            end
            else if (cmd.node_inc)
            begin
                node_reg <= node_reg + node_t'(1);
            end
            if (cmd.edge_rst)
            begin
                edge_reg <= '0;
            end
            else if (cmd.edge_inc)
            begin
                edge_reg <= edge_reg + EA_W'(1);
            end
            if (cmd.step_rst)
            begin
                step_reg <= '0;
            end
            else if (cmd.step_inc)
            begin
                step_reg <= step_reg + step_t'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NODE_BITS; b++)
        begin
            if (cmd.sum_clr)
            begin
                sum_reg[b] <= '0;
            end
            else if (cmd.sum_acc && node_reg[b])
            begin
                sum_reg[b] <= sat_add(sum_reg[b], cur_q);
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg.balanced    <= cmd.out_bal;
            out_data_reg.failed_step <= step_reg;
        end
    end

    assign in_ch.ready  = cmd.in_rdy;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    assign sts.in_fire   = in_fire;
    assign sts.in_last   = in_ch.data.last_edge;
    assign sts.node_last = node_reg == mask;
    assign sts.edge_none = cnt_reg == '0;
    assign sts.edge_last = (CNT_W'(edge_reg) + CNT_W'(1)) == cnt_reg;
    assign sts.step_end  = step_reg == step_count_reg;
    assign sts.bits_ok   = bits_ok;
    assign sts.div_done  = div_done;
    assign sts.deg_zero  = deg_q == '0;
    assign sts.out_free  = !out_valid_reg || out_ch.ready;

endmodule

[sv/rwbbc_ctrl.sv]
module rwbbc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  rwbbc_pkg::dp_sts_t sts,
    output rwbbc_pkg::dp_cmd_t cmd
);
    import rwbbc_pkg::*;

    typedef enum logic [19:0] {
        ST_IDLE  = 20'd1 << 0,
        ST_DCLR  = 20'd1 << 1,
        ST_DE_RD = 20'd1 << 2,
        ST_DD_RD = 20'd1 << 3,
        ST_DD_WR = 20'd1 << 4,
        ST_INIT  = 20'd1 << 5,
        ST_CHK   = 20'd1 << 6,
        ST_S_RD  = 20'd1 << 7,
        ST_S_ACC = 20'd1 << 8,
        ST_S_EV  = 20'd1 << 9,
        ST_NCLR  = 20'd1 << 10,
        ST_P_RD  = 20'd1 << 11,
        ST_P_SRC = 20'd1 << 12,
        ST_P_DIV = 20'd1 << 13,
        ST_P_DW  = 20'd1 << 14,
        ST_P_NRD = 20'd1 << 15,
        ST_P_NWR = 20'd1 << 16,
        ST_CP_RD = 20'd1 << 17,
        ST_CP_WR = 20'd1 << 18,
        ST_DONE  = 20'd1 << 19
    } state_t;

    state_t state_reg, state_next;
    logic   side_reg, side_next;
    logic   bal_reg, bal_next;

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        bal_next   = bal_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_rdy = 1'b1;
                if (sts.in_fire && sts.in_last)
                begin
                    cmd.node_rst = 1'b1;
                    cmd.edge_rst = 1'b1;
                    cmd.step_rst = 1'b1;
                    side_next    = 1'b0;
                    bal_next     = 1'b1;
                    state_next   = ST_DCLR;
                end
            end
            ST_DCLR:
            begin
                cmd.deg_clr_wr = 1'b1;
                if (sts.node_last)
                begin
                    cmd.node_rst = 1'b1;
                    state_next   = sts.edge_none ? ST_INIT : ST_DE_RD;
                end
                else
                begin
                    cmd.node_inc = 1'b1;
                end
            end
            ST_DE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_DD_RD;
            end
            ST_DD_RD:
            begin
                cmd.deg_rd = 1'b1;
                state_next = ST_DD_WR;
            end
            ST_DD_WR:
            begin
                cmd.deg_inc_wr = 1'b1;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = ST_DD_RD;
                end
                else
                begin
                    side_next = 1'b0;
                    if (sts.edge_last)
                    begin
                        cmd.edge_rst = 1'b1;
                        state_next   = ST_INIT;
                    end
                    else
                    begin
                        cmd.edge_inc = 1'b1;
                        state_next   = ST_DE_RD;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.cur_init_wr = 1'b1;
                if (sts.node_last)
                begin
                    cmd.node_rst = 1'b1;
                    state_next   = ST_CHK;
                end
                else
                begin
                    cmd.node_inc = 1'b1;
                end
            end
            ST_CHK:
            begin
                if (sts.step_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.sum_clr = 1'b1;
                    state_next  = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                cmd.cur_rd_node = 1'b1;
                state_next      = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (sts.node_last)
                begin
                    cmd.node_rst = 1'b1;
                    state_next   = ST_S_EV;
                end
                else
                begin
                    cmd.node_inc = 1'b1;
                    state_next   = ST_S_RD;
                end
            end
            ST_S_EV:
            begin
                if (!sts.bits_ok)
                begin
                    bal_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_NCLR;
                end
            end
            ST_NCLR:
            begin
                cmd.nxt_clr_wr = 1'b1;
                if (sts.node_last)
                begin
                    cmd.node_rst = 1'b1;
                    state_next   = sts.edge_none ? ST_CP_RD : ST_P_RD;
                end
                else
                begin
                    cmd.node_inc = 1'b1;
                end
            end
            ST_P_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_P_SRC;
            end
            ST_P_SRC:
            begin
                cmd.src_rd = 1'b1;
                state_next = ST_P_DIV;
            end
            ST_P_DIV, ST_P_NWR:
            begin
                if ((state_reg == ST_P_DIV) && !sts.deg_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_P_DW;
                end
                else
                begin
                    cmd.nxt_add_wr = state_reg == ST_P_NWR;
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = ST_P_SRC;
                    end
                    else
                    begin
                        side_next = 1'b0;
                        if (sts.edge_last)
                        begin
                            cmd.edge_rst = 1'b1;
                            state_next   = ST_CP_RD;
                        end
                        else
                        begin
                            cmd.edge_inc = 1'b1;
                            state_next   = ST_P_RD;
                        end
                    end
                end
            end
            ST_P_DW:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_P_NRD;
                end
            end
            ST_P_NRD:
            begin
                cmd.nxt_rd_dst = 1'b1;
                state_next     = ST_P_NWR;
            end
            ST_CP_RD:
            begin
                cmd.nxt_rd_node = 1'b1;
                state_next      = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                cmd.cur_copy_wr = 1'b1;
                if (sts.node_last)
                begin
                    cmd.node_rst = 1'b1;
                    cmd.step_inc = 1'b1;
                    state_next   = ST_CHK;
                end
                else
                begin
                    cmd.node_inc = 1'b1;
                    state_next   = ST_CP_RD;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_bal  = bal_reg;
                    cmd.clr_cnt  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= 1'b0;
            bal_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            bal_reg   <= bal_next;
        end
    end

endmodule

[sv/random_walk_bit_balance_check_unit.sv]
// edge requests without last_edge are taken one per cycle while the unit is idle
// a last_edge request gives its verdict after a check over N = 2^bit_count nodes
// (bit_count held to 1..10), E loaded edges and k steps checked; its length is set by the
// memory passes over nodes and edges and by the waits on the shared divider
// no new request is taken until the verdict is in the output register
// reset clears control state and sets step_count and bit_count to 1; memories are not cleared
`include "assert_macros.svh"

module random_walk_bit_balance_check_unit #(
    parameter int MAX_EDGES = rwbbc_pkg::DEFAULT_MAX_EDGES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rwbbc_in_if.sink                             in_ch,
    rwbbc_out_if.source                          out_ch,
    input  logic                                 cfg_we,
    input  logic [rwbbc_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx,
    input  logic [rwbbc_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);
    import rwbbc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rwbbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rwbbc_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    `RWB_ASSERT_NOW(a_load_not_idle, cmd.out_load, !cmd.in_rdy, "verdict loaded while idle")
    `RWB_ASSERT_NEXT(a_div_busy, cmd.div_start, !sts.div_done, "divider did not start")
    `RWB_ASSERT_NEXT(a_out_source, !out_ch.valid && !cmd.out_load, !out_ch.valid, "verdict appeared without load")
    `RWB_ASSERT_NOW(a_one_reader, cmd.cur_rd_node, !cmd.src_rd, "two reads on probability memory")

endmodule
